>>> rtl/trle_pkg.sv
// ----------------------------------------------------------------------------
// trle_pkg
// shared types, register indexes and pixel unpacking for the targa rle decoder
// ----------------------------------------------------------------------------
package trle_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RLE_MODE        = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BYTES_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_TOTAL     = 2'd2;

    localparam logic [2:0] BPP_MIN   = 3'd2;
    localparam logic [2:0] BPP_RGB   = 3'd3;
    localparam logic [2:0] BPP_MAX   = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    typedef struct packed {
        logic       hit;
        rgba_t      pixel;
        logic [7:0] repeat_cnt;
        logic       done;
    } step_t;

    // last byte of the pixel is b, the earlier ones are held
    function automatic rgba_t trle_unpack(input logic [2:0] bpp, input logic [7:0] p0,
                                          input logic [7:0] p1, input logic [7:0] p2,
                                          input logic [7:0] b);
        rgba_t px;
        px = '0;
        unique case (bpp)
            BPP_MAX:
            begin
                px.red   = p2;
                px.green = p1;
                px.blue  = p0;
                px.alpha = b;
            end
            BPP_RGB:
            begin
                px.red   = b;
                px.green = p1;
                px.blue  = p0;
                px.alpha = 8'h00;
            end
            default:
            begin
                // 1-5-5-5, high byte is b
                px.red   = {b[6:2], 3'b000};
                px.green = {b[1:0], p0[7:5], 3'b000};
                px.blue  = {p0[4:0], 3'b000};
                px.alpha = {b[7], 7'b0};
            end
        endcase
        return px;
    endfunction

endpackage

>>> rtl/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// targa pixel-data decoder, raw or run-length, to 8-bit rgba with repeat count
// ----------------------------------------------------------------------------
// Takes one data byte per cycle. Each byte is decoded in the cycle it is taken
// and a finished pixel lands in the result register at that edge, so a pixel
// beat appears in the cycle after its last byte. in_ready is high while the
// result register is empty or draining, so bytes stream at one per cycle and
// only a stalled output holds the input back. Packet headers and leading pixel
// bytes give no beat. Configuration must be written while idle; not enforced.
module tga_rle_pixel_decoder #(
    parameter int COUNT_BITS = trle_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [trle_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [trle_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          data_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [7:0]                          red,
    output logic [7:0]                          green,
    output logic [7:0]                          blue,
    output logic [7:0]                          alpha,
    output logic [7:0]                          repeat_res,
    output logic                                image_done
);
    import trle_pkg::*;

    step_t step;
    logic  beat;

    assign in_ready = !out_valid || out_ready;
    assign beat     = in_valid && in_ready;

    trle_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .beat      (beat),
        .data_byte (data_byte),
        .step      (step)
    );

    trle_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (beat && step.hit),
        .step       (step),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .repeat_res (repeat_res),
        .image_done (image_done)
    );

    // repeat count of a pixel beat is never zero and never above a full packet
    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (repeat_res != 8'd0) && (repeat_res <= 8'd128))
        else $error("repeat count out of range");

    // a completed pixel always shows up as an output beat
    a_pixel_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && step.hit) |=> out_valid)
        else $error("decoded pixel lost");

    // a stalled beat is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !beat)
        else $error("byte taken while result stalled");

endmodule

>>> rtl/trle_ctrl.sv
// ----------------------------------------------------------------------------
// trle_ctrl
// config registers, packet and pixel state, per-byte decode step
// ----------------------------------------------------------------------------
module trle_ctrl #(
    parameter int COUNT_BITS = trle_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [trle_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [trle_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                beat,
    input  logic [7:0]                          data_byte,
    output trle_pkg::step_t                     step
);
    import trle_pkg::*;

    logic                      rle_mode_reg;
    logic [2:0]                bpp_cfg_reg;
    logic [CFG_DATA_BITS-1:0]  pixel_total_reg;

    logic [2:0]            byte_phase_reg, byte_phase_next;
    logic                  expect_header_reg, expect_header_next;
    logic                  packet_is_run_reg, packet_is_run_next;
    logic [7:0]            packet_left_reg, packet_left_next;
    logic [COUNT_BITS-1:0] pixels_left_reg, pixels_left_next;
    logic [7:0]            pixel_bytes_reg [3];

    logic [2:0]                          bpp;
    logic [COUNT_BITS+CFG_DATA_BITS-1:0] total_wide;
    logic [COUNT_BITS-1:0]               total_load;
    logic [COUNT_BITS-1:0]               pl_cur;
    logic [7:0]                          n;
    logic [COUNT_BITS-1:0]               n_ext;
    logic                                byte_wr;

    assign total_wide = {{COUNT_BITS{1'b0}}, pixel_total_reg};
    assign total_load = (total_wide[COUNT_BITS-1:0] == '0) ? COUNT_BITS'(1)
                                                           : total_wide[COUNT_BITS-1:0];

    always_comb
    begin
        bpp = bpp_cfg_reg;
        if (bpp_cfg_reg < BPP_MIN)
        begin
            bpp = BPP_MIN;
        end
        if (bpp_cfg_reg > BPP_MAX)
        begin
            bpp = BPP_MAX;
        end
    end

    always_comb
    begin
        pl_cur             = (pixels_left_reg == '0) ? total_load : pixels_left_reg;
        byte_phase_next    = byte_phase_reg;
        expect_header_next = expect_header_reg;
        packet_is_run_next = packet_is_run_reg;
        packet_left_next   = packet_left_reg;
        pixels_left_next   = pl_cur;
        byte_wr            = 1'b0;
        n                  = 8'd1;
        n_ext              = '0;
        step               = '0;
        step.pixel         = trle_unpack(bpp, pixel_bytes_reg[0], pixel_bytes_reg[1],
                                         pixel_bytes_reg[2], data_byte);

        priority if (rle_mode_reg && expect_header_reg)
        begin
            packet_is_run_next = data_byte[7];
            packet_left_next   = {1'b0, data_byte[6:0]} + 8'd1;
            expect_header_next = 1'b0;
            byte_phase_next    = 3'd0;
        end
        else if (byte_phase_reg < (bpp - 3'd1))
        begin
            byte_wr         = 1'b1;
            byte_phase_next = byte_phase_reg + 3'd1;
        end
        else
        begin
            if (rle_mode_reg && packet_is_run_reg && (packet_left_reg != 8'd0))
            begin
                n = packet_left_reg;
            end
            n_ext = COUNT_BITS'(n);
            if (n_ext > pl_cur)
            begin
                n     = pl_cur[7:0];
                n_ext = pl_cur;
            end
            pixels_left_next = pl_cur - n_ext;

            if (rle_mode_reg)
            begin
                if (packet_is_run_reg || (packet_left_reg <= 8'd1))
                begin
                    packet_left_next   = 8'd0;
                    expect_header_next = 1'b1;
                end
                else
                begin
                    packet_left_next = packet_left_reg - 8'd1;
                end
            end
            byte_phase_next = 3'd0;

            step.hit        = 1'b1;
            step.repeat_cnt = n;
            step.done       = (pixels_left_next == '0);
            if (pixels_left_next == '0)
            begin
                expect_header_next = 1'b1;
                packet_left_next   = 8'd0;
                packet_is_run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_mode_reg      <= 1'b0;
            bpp_cfg_reg       <= BPP_RGB;
            pixel_total_reg   <= CFG_DATA_BITS'(1);
            byte_phase_reg    <= 3'd0;
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            packet_left_reg   <= 8'd0;
            pixels_left_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RLE_MODE:        rle_mode_reg    <= cfg_data[0];
                    CFG_BYTES_PER_PIXEL: bpp_cfg_reg     <= cfg_data[2:0];
                    CFG_PIXEL_TOTAL:     pixel_total_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (beat)
            begin
                byte_phase_reg    <= byte_phase_next;
                expect_header_reg <= expect_header_next;
                packet_is_run_reg <= packet_is_run_next;
                packet_left_reg   <= packet_left_next;
                pixels_left_reg   <= pixels_left_next;
            end
        end
    end

    // held pixel bytes, no reset
    always_ff @(posedge clk)
    begin
        if (beat && byte_wr)
        begin
            pixel_bytes_reg[byte_phase_reg[1:0]] <= data_byte;
        end
    end

endmodule

>>> rtl/trle_out.sv
// ----------------------------------------------------------------------------
// trle_out
// result register holding one decoded pixel beat for the output channel
// ----------------------------------------------------------------------------
module trle_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  trle_pkg::step_t step,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [7:0]      red,
    output logic [7:0]      green,
    output logic [7:0]      blue,
    output logic [7:0]      alpha,
    output logic [7:0]      repeat_res,
    output logic            image_done
);
    import trle_pkg::*;

    logic       valid_reg, valid_next;
    rgba_t      pixel_reg;
    logic [7:0] repeat_reg;
    logic       done_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg  <= step.pixel;
            repeat_reg <= step.repeat_cnt;
            done_reg   <= step.done;
        end
    end

    assign out_valid  = valid_reg;
    assign red        = pixel_reg.red;
    assign green      = pixel_reg.green;
    assign blue       = pixel_reg.blue;
    assign alpha      = pixel_reg.alpha;
    assign repeat_res = repeat_reg;
    assign image_done = done_reg;

endmodule
